### rtl/bodd_pkg.sv
// shared constants, types and helpers of the byte-offset delta decompressor
package bodd_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 32;
    localparam int PROG_W  = 3;
    localparam int PHASE_W = 3;

    // start marker, in stream order
    localparam logic [BYTE_W-1:0] MARK_B0 = 8'h0C;
    localparam logic [BYTE_W-1:0] MARK_B1 = 8'h1A;
    localparam logic [BYTE_W-1:0] MARK_B2 = 8'h04;
    localparam logic [BYTE_W-1:0] MARK_B3 = 8'hD5;

    // escape codes
    localparam logic [BYTE_W-1:0] ESC8  = 8'h80;
    localparam logic [15:0]       ESC16 = 16'h8000;

    // marker hunt progress, anything from PROG_FOUND up means decoding
    localparam logic [PROG_W-1:0] PROG_NONE  = 3'd0;
    localparam logic [PROG_W-1:0] PROG_ONE   = 3'd1;
    localparam logic [PROG_W-1:0] PROG_FOUND = 3'd4;

    // decode phases
    localparam logic [PHASE_W-1:0] PH_BYTE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_W16_0 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_W16_1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_W32_0 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_W32_1 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_W32_2 = 3'd5;
    localparam logic [PHASE_W-1:0] PH_W32_3 = 3'd6;

    // decoder to accumulator
    typedef struct packed {
        logic               emit;
        logic [PIXEL_W-1:0] delta;
    } t_dec_out;

    // expected marker byte for a hunt progress below PROG_FOUND
    function automatic logic [BYTE_W-1:0] marker_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0: b = MARK_B0;
            2'd1: b = MARK_B1;
            2'd2: b = MARK_B2;
            2'd3: b = MARK_B3;
            default: b = MARK_B0;
        endcase
        return b;
    endfunction

endpackage

### rtl/bodd_stream_if.sv
// valid/ready stream interfaces for raw bytes and for pixels
interface bodd_byte_if;
    import bodd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bodd_pixel_if;
    import bodd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [PIXEL_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

### rtl/bodd_decode.sv
// marker hunt and byte-offset delta decoding state machine
module bodd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bodd_pkg::BYTE_W-1:0]   i_byte,
    output bodd_pkg::t_dec_out            o_dec
);
    import bodd_pkg::*;

    logic [PROG_W-1:0]  r_prog,  n_prog;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PIXEL_W-1:0] r_part,  n_part;
    logic [15:0]        w16;
    logic               emit;
    logic [PIXEL_W-1:0] delta;

    assign w16 = {i_byte, r_part[7:0]};

    always_comb begin
        n_prog  = r_prog;
        n_phase = r_phase;
        n_part  = r_part;
        emit    = 1'b0;
        delta   = r_part;
        if (r_prog < PROG_FOUND) begin
            if (i_byte == marker_byte(r_prog[1:0])) begin
                n_prog = r_prog + PROG_W'(1);
            end else if (i_byte == MARK_B0) begin
                n_prog = PROG_ONE;
            end else begin
                n_prog = PROG_NONE;
            end
        end else begin
            case (r_phase)
                PH_BYTE: begin
                    if (i_byte == ESC8) begin
                        n_phase = PH_W16_0;
                    end else begin
                        emit  = 1'b1;
                        delta = {{(PIXEL_W-BYTE_W){i_byte[BYTE_W-1]}}, i_byte};
                    end
                end
                PH_W16_0: begin
                    n_part  = {{(PIXEL_W-BYTE_W){1'b0}}, i_byte};
                    n_phase = PH_W16_1;
                end
                PH_W16_1: begin
                    if (w16 == ESC16) begin
                        n_part  = {{(PIXEL_W-16){1'b0}}, w16};
                        n_phase = PH_W32_0;
                    end else begin
                        emit    = 1'b1;
                        delta   = {{(PIXEL_W-16){w16[15]}}, w16};
                        n_phase = PH_BYTE;
                    end
                end
                PH_W32_0: begin
                    n_part  = {{(PIXEL_W-BYTE_W){1'b0}}, i_byte};
                    n_phase = PH_W32_1;
                end
                PH_W32_1: begin
                    n_part[15:8] = i_byte;
                    n_phase      = PH_W32_2;
                end
                PH_W32_2: begin
                    n_part[23:16] = i_byte;
                    n_phase       = PH_W32_3;
                end
                PH_W32_3: begin
                    emit    = 1'b1;
                    delta   = {i_byte, r_part[23:0]};
                    n_phase = PH_BYTE;
                end
                default: begin
                    n_phase = PH_BYTE;
                end
            endcase
            if (emit) begin
                n_part = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog  <= PROG_NONE;
            r_phase <= PH_BYTE;
            r_part  <= '0;
        end else if (i_step) begin
            r_prog  <= n_prog;
            r_phase <= n_phase;
            r_part  <= n_part;
        end
    end

    assign o_dec.emit  = emit;
    assign o_dec.delta = delta;

endmodule

### rtl/bodd_accum.sv
// running sum and pixel output register
module bodd_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  bodd_pkg::t_dec_out             i_dec,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [bodd_pkg::PIXEL_W-1:0]   o_out_data
);
    import bodd_pkg::*;

    logic [PIXEL_W-1:0] r_sum;
    logic [PIXEL_W-1:0] n_sum;
    logic               r_vld;
    logic [PIXEL_W-1:0] r_data;

    assign n_sum = r_sum + i_dec.delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_vld <= 1'b0;
        end else if (i_step && i_dec.emit) begin
            r_sum <= n_sum;
            r_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_dec.emit) begin
            r_data <= n_sum;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_data  = r_data;

endmodule

### rtl/byte_offset_delta_decompressor_core.sv
// top level of the byte-offset delta decompressor
//
// usage
//   i_byte_ch  : one raw byte of the compressed stream per word (valid/ready)
//   o_pixel_ch : one reconstructed 32-bit signed pixel per word (valid/ready)
//   bytes before the start marker 0C 1A 04 D5 (four in a row) are dropped;
//   after it each delta (one byte, 0x80 + int16, or 0x80 + 0x8000 + int32,
//   little endian) adds into a wrapping 32-bit sum that goes out as a pixel
// timing
//   a byte lands in the input register at its accept edge, is decoded and
//   summed combinationally there, and the pixel is loaded into the output
//   register at the edge on which that byte steps on; a byte that completes
//   a delta waits there while the output register is full and not drained
//   throughput is one byte per cycle while no such byte waits
// reset
//   synchronous, active low: hunt restarts, sum cleared, both registers empty
// stall
//   while a pixel waits in the output register, the byte in the input
//   register still moves on if it completes no delta; one that completes a
//   delta waits, and input ready drops only then
module byte_offset_delta_decompressor_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bodd_byte_if.sink    i_byte_ch,
    bodd_pixel_if.source o_pixel_ch
);
    import bodd_pkg::*;

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    t_dec_out          dec;
    logic              out_free;
    logic              step;
    logic              in_ready;
    logic              out_valid;
    logic [PIXEL_W-1:0] out_data;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid || o_pixel_ch.ready;
    // the held byte moves on unless it makes a pixel with nowhere to go
    assign step     = r_in_vld && (!dec.emit || out_free);
    assign in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte_ch.valid) begin
            r_in_byte <= i_byte_ch.in_byte;
        end
    end

    // marker hunt and delta decode
    bodd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_dec   (dec)
    );

    // running sum and result register
    bodd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_dec       (dec),
        .i_out_ready (o_pixel_ch.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign i_byte_ch.ready        = in_ready;
    assign o_pixel_ch.valid       = out_valid;
    assign o_pixel_ch.pixel_value = out_data;

    // a pixel is never written over while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_pixel_ch.ready |-> !(step && dec.emit))
        else $error("pending pixel overwritten");

    // a pending byte that makes no pixel never blocks the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !dec.emit |-> i_byte_ch.ready)
        else $error("input stalled by a byte that makes no pixel");

    // a new pixel appears only after a step that emits
    a_pixel_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(step && dec.emit))
        else $error("pixel without a completed delta");

    // both registers empty right after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && !r_in_vld)
        else $error("registers not empty after reset");

endmodule

### dv/tb_byte_offset_delta_decompressor_core.sv
// self-checking testbench of the byte-offset delta decompressor core
module tb_byte_offset_delta_decompressor_core;
    import bodd_pkg::*;

    // traffic shapes: who idles, and how often (in percent)
    typedef enum int {
        TR_FREE,
        TR_TX_IDLE,
        TR_RX_STALL,
        TR_BOTH,
        TR_HOLD
    } t_traffic;

    localparam int TX_IDLE_PCT [5] = '{0, 70, 0, 9, 0};
    localparam int RX_STALL_PCT[5] = '{0, 0, 70, 9, 0};

    // random part is split into segments, one traffic shape each
    localparam int       SEG_COUNT = 7;
    localparam int       SEG_BYTES = 200;
    localparam t_traffic SEG_MODE [SEG_COUNT] = '{TR_FREE, TR_TX_IDLE, TR_RX_STALL, TR_HOLD,
                                                  TR_BOTH, TR_RX_STALL, TR_FREE};
    // segments that start only once every pending pixel is out
    localparam bit       SEG_DRAIN[SEG_COUNT] = '{0, 0, 1, 0, 1, 0, 1};

    localparam int HOLD_CYCLES = 400;   // long output hold-off in the hold segment
    localparam int QUIET_LIMIT = 3000;  // cycles without any word moved before giving up
    localparam int TAIL_CYCLES = 8;     // settle time after the last pixel

    localparam logic [BYTE_W-1:0] START_MARK[4] = '{MARK_B0, MARK_B1, MARK_B2, MARK_B3};

    typedef struct {
        logic [BYTE_W-1:0] data;
        t_traffic          mode;
        bit                drain_first;
    } t_byte_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bodd_byte_if  byte_ch ();
    bodd_pixel_if pix_ch ();

    byte_offset_delta_decompressor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_ch  (byte_ch),
        .o_pixel_ch (pix_ch)
    );

    always #6 i_clk = ~i_clk;

    // pending raw bytes and pixels still owed by the block
    t_byte_item                byte_feed[$];
    logic signed [PIXEL_W-1:0] expected_pixels[$];

    // mirror of the decoder state
    logic [PROG_W-1:0]         hunt_prog = PROG_NONE;
    logic [PHASE_W-1:0]        dec_phase = PH_BYTE;
    logic [PIXEL_W-1:0]        delta_acc = '0;
    logic signed [PIXEL_W-1:0] pixel_sum = '0;

    t_traffic tx_mode     = TR_FREE;
    int       err_count   = 0;
    int       hold_left   = 0;
    bit       hold_done   = 1'b0;
    int       quiet_cycles = 0;

    // advance the mirrored decoder by one accepted byte, queue the pixel it completes
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        bit done;
        done = 1'b0;
        if (hunt_prog < PROG_FOUND) begin
            // consecutive marker match, a stray 0x0C restarts at one
            if (b == START_MARK[hunt_prog[1:0]])
                hunt_prog = hunt_prog + 1'b1;
            else if (b == MARK_B0)
                hunt_prog = PROG_ONE;
            else
                hunt_prog = PROG_NONE;
            return;
        end
        case (dec_phase)
            PH_BYTE: begin
                if (b == ESC8) begin
                    dec_phase = PH_W16_0;
                end else begin
                    delta_acc = {{24{b[7]}}, b};
                    done = 1'b1;
                end
            end
            PH_W16_0: begin
                delta_acc = {24'd0, b};
                dec_phase = PH_W16_1;
            end
            PH_W16_1: begin
                delta_acc[15:8] = b;
                if (delta_acc[15:0] == ESC16) begin
                    dec_phase = PH_W32_0;
                end else begin
                    delta_acc = {{16{delta_acc[15]}}, delta_acc[15:0]};
                    dec_phase = PH_BYTE;
                    done = 1'b1;
                end
            end
            PH_W32_0: begin
                delta_acc = {24'd0, b};
                dec_phase = PH_W32_1;
            end
            PH_W32_1: begin
                delta_acc[15:8] = b;
                dec_phase = PH_W32_2;
            end
            PH_W32_2: begin
                delta_acc[23:16] = b;
                dec_phase = PH_W32_3;
            end
            PH_W32_3: begin
                delta_acc[31:24] = b;
                dec_phase = PH_BYTE;
                done = 1'b1;
            end
            default: begin
                dec_phase = PH_BYTE;
            end
        endcase
        if (done) begin
            // wraps modulo 2^32
            pixel_sum = pixel_sum + delta_acc;
            delta_acc = '0;
            expected_pixels.push_back(pixel_sum);
        end
    endfunction

    function automatic void feed_byte(input logic [BYTE_W-1:0] data, input t_traffic mode);
        t_byte_item it;
        it.data        = data;
        it.mode        = mode;
        it.drain_first = 1'b0;
        byte_feed.push_back(it);
    endfunction

    // byte driver: predicts on accept, then offers the next byte or idles
    always @(posedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            byte_ch.valid   <= 1'b0;
            byte_ch.in_byte <= '0;
        end else begin
            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.in_byte);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (byte_feed.size() != 0
                    && !(byte_feed[0].drain_first && expected_pixels.size() != 0)
                    && $urandom_range(99) >= TX_IDLE_PCT[int'(byte_feed[0].mode)]) begin
                    nxt = byte_feed.pop_front();
                    byte_ch.valid   <= 1'b1;
                    byte_ch.in_byte <= nxt.data;
                    tx_mode         <= nxt.mode;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor: checks each accepted word and drives ready
    always @(posedge i_clk) begin
        logic signed [PIXEL_W-1:0] want_pix;
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_value unexpected: actual %0d", pix_ch.pixel_value);
                    err_count++;
                end else begin
                    want_pix = expected_pixels.pop_front();
                    if (pix_ch.pixel_value !== want_pix) begin
                        $error("pixel_value mismatch: expected %0d, actual %0d",
                               want_pix, pix_ch.pixel_value);
                        err_count++;
                    end
                end
            end
            // one long hold-off while the sender keeps pushing, so the core backs up
            if (tx_mode == TR_HOLD && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= ($urandom_range(99) >= RX_STALL_PCT[int'(tx_mode)]);
            end
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL byte_offset_delta_decompressor_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                start;
        int                r;
        logic [BYTE_W-1:0] b;
        logic [15:0]       w;
        logic [31:0]       d;

        // hunt: broken marker on a plain byte, then on a repeated 0x0C, then the marker
        foreach (START_MARK[i]) if (i < 2) feed_byte(START_MARK[i], TR_FREE);
        feed_byte(8'h00, TR_FREE);
        feed_byte(MARK_B0, TR_FREE);
        foreach (START_MARK[i]) feed_byte(START_MARK[i], TR_FREE);
        // one-byte extremes
        feed_byte(8'h7F, TR_FREE);
        feed_byte(8'h81, TR_FREE);
        feed_byte(8'h00, TR_FREE);
        feed_byte(8'hFF, TR_FREE);
        // int16 extremes
        feed_byte(ESC8, TR_FREE); feed_byte(8'hFF, TR_FREE); feed_byte(8'h7F, TR_FREE);
        feed_byte(ESC8, TR_FREE); feed_byte(8'h01, TR_FREE); feed_byte(8'h80, TR_FREE);
        // int32 max on top of a negative sum
        feed_byte(ESC8, TR_FREE); feed_byte(ESC16[7:0], TR_FREE); feed_byte(ESC16[15:8], TR_FREE);
        feed_byte(8'hFF, TR_FREE); feed_byte(8'hFF, TR_FREE);
        feed_byte(8'hFF, TR_FREE); feed_byte(8'h7F, TR_FREE);

        // random delta stream, mostly well-formed deltas with some raw noise
        for (int s = 0; s < SEG_COUNT; s++) begin
            start = byte_feed.size();
            while (byte_feed.size() - start < SEG_BYTES) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    // any one-byte delta, the escape value skipped
                    b = BYTE_W'($urandom_range(254));
                    if (b >= ESC8)
                        b = b + 1'b1;
                    feed_byte(b, SEG_MODE[s]);
                end else if (r < 63) begin
                    feed_byte(BYTE_W'($urandom_range(255)), SEG_MODE[s]);
                end else if (r < 85) begin
                    w = 16'($urandom_range(16'hFFFF));
                    case ($urandom_range(11))
                        0: w = 16'h7FFF;
                        1: w = 16'h8001;
                        2: w = 16'hFFFF;
                        3: w = 16'h0000;
                        default: ;
                    endcase
                    if (w == ESC16)
                        w = 16'h8001;
                    feed_byte(ESC8, SEG_MODE[s]);
                    feed_byte(w[7:0], SEG_MODE[s]);
                    feed_byte(w[15:8], SEG_MODE[s]);
                end else begin
                    d = $urandom();
                    case ($urandom_range(9))
                        0: d = 32'h8000_0000;
                        1: d = 32'h7FFF_FFFF;
                        2: d = 32'hFFFF_FFFF;
                        3: d = 32'h0000_8000;
                        default: ;
                    endcase
                    feed_byte(ESC8, SEG_MODE[s]);
                    feed_byte(ESC16[7:0], SEG_MODE[s]);
                    feed_byte(ESC16[15:8], SEG_MODE[s]);
                    for (int k = 0; k < 4; k++)
                        feed_byte(d[8*k +: 8], SEG_MODE[s]);
                end
            end
            byte_feed[start].drain_first = SEG_DRAIN[s];
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || byte_ch.valid)
            @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("PASS byte_offset_delta_decompressor_core");
        else
            $display("FAIL byte_offset_delta_decompressor_core");
        $finish;
    end

endmodule
